>>> hdl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// Tank pump controller package
// Shared types, codes, reset values and helper functions of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tpc_pkg;

   localparam int TICKS_PER_MINUTE = 60;

   localparam int NETWORK_WIDTH = 14;
   localparam int MINUTES_WIDTH = 8;
   localparam int CONFIRM_WIDTH = 3;
   localparam int DELAY_WIDTH   = 4;
   localparam int SECONDS_WIDTH = 15;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   // Action codes of an input item.
   localparam logic [1:0] ACTION_REPORT = 2'd0;
   localparam logic [1:0] ACTION_BUTTON = 2'd1;
   localparam logic [1:0] ACTION_TICK   = 2'd2;

   // Status codes carried by a level report.
   localparam logic [1:0] STATUS_FULL   = 2'd0;
   localparam logic [1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_NORMAL = 2'd2;
   localparam logic [1:0] STATUS_OTHER  = 2'd3;

   // Accepted level codes.
   localparam logic [1:0] LEVEL_FULL   = 2'd0;
   localparam logic [1:0] LEVEL_EMPTY  = 2'd1;
   localparam logic [1:0] LEVEL_NORMAL = 2'd2;

   // Display modes.
   localparam logic [1:0] DISP_BLANK  = 2'd0;
   localparam logic [1:0] DISP_FULL   = 2'd1;
   localparam logic [1:0] DISP_EMPTY  = 2'd2;
   localparam logic [1:0] DISP_NUMBER = 2'd3;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_NETWORK_ID    = 2'd0;
   localparam logic [1:0] CSR_RUN_MINUTES   = 2'd1;
   localparam logic [1:0] CSR_CONFIRM_COUNT = 2'd2;
   localparam logic [1:0] CSR_STOP_DELAY    = 2'd3;

   localparam logic [NETWORK_WIDTH-1:0] NETWORK_ID_RESET    = 14'd2012;
   localparam logic [MINUTES_WIDTH-1:0] RUN_MINUTES_RESET   = 8'd30;
   localparam logic [CONFIRM_WIDTH-1:0] CONFIRM_COUNT_RESET = 3'd3;
   localparam logic [DELAY_WIDTH-1:0]   STOP_DELAY_RESET    = 4'd5;

   localparam logic [MINUTES_WIDTH-1:0] RUN_MINUTES_LOW     = 8'd1;
   localparam logic [MINUTES_WIDTH-1:0] RUN_MINUTES_HIGH    = 8'd180;
   localparam logic [MINUTES_WIDTH-1:0] RUN_MINUTES_DEFAULT = 8'd30;

   localparam logic [SECONDS_WIDTH-1:0] SECONDS_RESET =
      SECONDS_WIDTH'(RUN_MINUTES_RESET * TICKS_PER_MINUTE);

   // Reciprocal of the tick count per minute, scaled by two to the sixteenth.
   localparam int RECIP_SHIFT = 16;
   localparam logic [31:0] MINUTE_RECIP = 32'((1 << RECIP_SHIFT) / TICKS_PER_MINUTE);

   typedef struct packed {
      logic [NETWORK_WIDTH-1:0] network_id;
      logic [MINUTES_WIDTH-1:0] run_minutes;
      logic [CONFIRM_WIDTH-1:0] confirm_count;
      logic [DELAY_WIDTH-1:0]   stop_delay;
   } cfg_type;

   typedef struct packed {
      logic [1:0]               action;
      logic                     msg_complete;
      logic [NETWORK_WIDTH-1:0] report_network;
      logic [1:0]               status_code;
   } item_type;

   typedef struct packed {
      logic                     pump_running;
      logic [SECONDS_WIDTH-1:0] seconds_left;
      logic [CONFIRM_WIDTH-1:0] full_streak;
      logic [CONFIRM_WIDTH-1:0] empty_streak;
      logic [CONFIRM_WIDTH-1:0] normal_streak;
      logic [DELAY_WIDTH-1:0]   stop_streak;
      logic [1:0]               level_held;
      logic [1:0]               shown_mode;
      logic [MINUTES_WIDTH-1:0] shown_minutes;
   } state_type;

   localparam state_type STATE_RESET = '{
      pump_running:  1'b0,
      seconds_left:  SECONDS_RESET,
      full_streak:   '0,
      empty_streak:  '0,
      normal_streak: '0,
      stop_streak:   '0,
      level_held:    LEVEL_NORMAL,
      shown_mode:    DISP_BLANK,
      shown_minutes: '0
   };

   // Run time in ticks; out-of-range minutes fall back to the default.
   function automatic logic [SECONDS_WIDTH-1:0] reload_value(
      input logic [MINUTES_WIDTH-1:0] minutes
   );
      logic [MINUTES_WIDTH-1:0] m;
      logic [31:0]              p;
      m = minutes;
      if (m < RUN_MINUTES_LOW || m > RUN_MINUTES_HIGH) begin
         m = RUN_MINUTES_DEFAULT;
      end
      p = 32'(m) * 32'(TICKS_PER_MINUTE);
      return p[SECONDS_WIDTH-1:0];
   endfunction

   // Minutes left for display: seconds divided by the tick count, plus one,
   // saturated to the display width. The quotient estimate from the
   // reciprocal is at most one low and is fixed by one compare.
   function automatic logic [MINUTES_WIDTH-1:0] minutes_left(
      input logic [SECONDS_WIDTH-1:0] seconds
   );
      logic [31:0] prod;
      logic [15:0] q;
      logic [31:0] back;
      logic [16:0] rem;
      logic [16:0] mins;
      prod = 32'(seconds) * MINUTE_RECIP;
      q    = prod[31:RECIP_SHIFT];
      back = 32'(q) * 32'(TICKS_PER_MINUTE);
      rem  = 17'(seconds) - back[16:0];
      if (rem >= 17'(TICKS_PER_MINUTE)) begin
         q = q + 16'd1;
      end
      mins = 17'(q) + 17'd1;
      if (mins > 17'd255) begin
         mins = 17'd255;
      end
      return mins[MINUTES_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

>>> hdl/tpc_update.sv
// ----------------------------------------------------------------------------
// Tank pump controller state update
// Computes the controller state after one level report, button press or tick.
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_update (
   input  wire tpc_pkg::cfg_type   cfg,
   input  wire tpc_pkg::item_type  item,
   input  wire tpc_pkg::state_type state_cur,
   output tpc_pkg::state_type      state_nxt
);

   logic                                  report_ok;
   logic [tpc_pkg::CONFIRM_WIDTH-1:0]     full_inc;
   logic [tpc_pkg::CONFIRM_WIDTH-1:0]     empty_inc;
   logic [tpc_pkg::CONFIRM_WIDTH-1:0]     normal_inc;
   logic [tpc_pkg::DELAY_WIDTH-1:0]       stop_inc;
   logic [tpc_pkg::SECONDS_WIDTH-1:0]     seconds_dec;
   logic [tpc_pkg::SECONDS_WIDTH-1:0]     reload;

   assign report_ok  = item.msg_complete && (item.report_network == cfg.network_id);
   assign full_inc   = state_cur.full_streak + 3'd1;
   assign empty_inc  = state_cur.empty_streak + 3'd1;
   assign normal_inc = state_cur.normal_streak + 3'd1;
   assign stop_inc   = state_cur.stop_streak + 4'd1;
   assign seconds_dec = (state_cur.seconds_left != '0) ?
                        state_cur.seconds_left - 15'd1 : '0;
   assign reload     = tpc_pkg::reload_value(cfg.run_minutes);

   always_comb begin
      state_nxt = state_cur;
      unique case (item.action)
         tpc_pkg::ACTION_REPORT: begin
            if (report_ok) begin
               state_nxt.full_streak   = '0;
               state_nxt.empty_streak  = '0;
               state_nxt.normal_streak = '0;
               unique case (item.status_code)
                  tpc_pkg::STATUS_FULL: begin
                     state_nxt.shown_mode = tpc_pkg::DISP_FULL;
                     if (full_inc >= cfg.confirm_count) begin
                        state_nxt.pump_running = 1'b0;
                        state_nxt.seconds_left = reload;
                        state_nxt.level_held   = tpc_pkg::LEVEL_FULL;
                     end else begin
                        state_nxt.full_streak = full_inc;
                     end
                  end
                  tpc_pkg::STATUS_EMPTY: begin
                     state_nxt.shown_mode = tpc_pkg::DISP_EMPTY;
                     if (empty_inc >= cfg.confirm_count) begin
                        state_nxt.pump_running = 1'b1;
                        state_nxt.level_held   = tpc_pkg::LEVEL_EMPTY;
                     end else begin
                        state_nxt.empty_streak = empty_inc;
                     end
                  end
                  tpc_pkg::STATUS_NORMAL: begin
                     if (normal_inc >= cfg.confirm_count) begin
                        state_nxt.level_held = tpc_pkg::LEVEL_NORMAL;
                     end else begin
                        state_nxt.normal_streak = normal_inc;
                     end
                  end
                  tpc_pkg::STATUS_OTHER: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         tpc_pkg::ACTION_BUTTON: begin
            state_nxt.pump_running = !state_cur.pump_running;
            if (!state_cur.pump_running) begin
               state_nxt.seconds_left = reload;
            end
         end
         tpc_pkg::ACTION_TICK: begin
            if (state_cur.pump_running) begin
               state_nxt.seconds_left  = seconds_dec;
               state_nxt.shown_mode    = tpc_pkg::DISP_NUMBER;
               state_nxt.shown_minutes = tpc_pkg::minutes_left(seconds_dec);
               if (seconds_dec == '0 || state_cur.level_held == tpc_pkg::LEVEL_FULL) begin
                  if (stop_inc >= cfg.stop_delay) begin
                     state_nxt.pump_running = 1'b0;
                     state_nxt.seconds_left = reload;
                     state_nxt.stop_streak  = '0;
                     state_nxt.shown_mode   = tpc_pkg::DISP_BLANK;
                  end else begin
                     state_nxt.stop_streak = stop_inc;
                  end
               end else begin
                  state_nxt.stop_streak = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/tank_pump_controller_unit.sv
// ----------------------------------------------------------------------------
// Tank pump controller unit
// Top level: input register, state update, result register and register port.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while req_stall is low and returns
// exactly one result per item. Each item passes through the input register,
// the combinational state update and then the result register. A result held
// in the result register does not block the next input transfer unless both
// registers are full. The user must write configuration registers through the
// register port only while the unit is idle; the unit does not enforce this.
`default_nettype none

module tank_pump_controller_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_action,
   input  wire logic                                 req_msg_complete,
   input  wire logic [tpc_pkg::NETWORK_WIDTH-1:0]    req_report_network,
   input  wire logic [1:0]                           req_status_code,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_pump_on,
   output logic [1:0]                                rsp_level_state,
   output logic [1:0]                                rsp_display_mode,
   output logic [tpc_pkg::MINUTES_WIDTH-1:0]         rsp_display_minutes,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [tpc_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  wire logic [tpc_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [tpc_pkg::CSR_DATA_WIDTH-1:0]        prdata,
   output logic                                      pready
);

   tpc_pkg::cfg_type   cfg_ff, cfg_in;
   tpc_pkg::state_type state_ff, state_in;
   tpc_pkg::item_type  item_ff;

   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_ready, advance, accept, csr_write;
   logic [1:0] csr_index;

   logic                               out_pump_ff;
   logic [1:0]                         out_level_ff;
   logic [1:0]                         out_mode_ff;
   logic [tpc_pkg::MINUTES_WIDTH-1:0]  out_minutes_ff;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !out_ready);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   tpc_update u_update (
      .cfg       (cfg_ff),
      .item      (item_ff),
      .state_cur (state_ff),
      .state_nxt (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= tpc_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.action         <= req_action;
         item_ff.msg_complete   <= req_msg_complete;
         item_ff.report_network <= req_report_network;
         item_ff.status_code    <= req_status_code;
      end
      if (advance) begin
         out_pump_ff    <= state_in.pump_running;
         out_level_ff   <= state_in.level_held;
         out_mode_ff    <= state_in.shown_mode;
         out_minutes_ff <= (state_in.shown_mode == tpc_pkg::DISP_NUMBER) ?
                           state_in.shown_minutes : '0;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_pump_on         = out_pump_ff;
   assign rsp_level_state     = out_level_ff;
   assign rsp_display_mode    = out_mode_ff;
   assign rsp_display_minutes = out_minutes_ff;

   // Register port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            tpc_pkg::CSR_NETWORK_ID:
               cfg_in.network_id = pwdata[tpc_pkg::NETWORK_WIDTH-1:0];
            tpc_pkg::CSR_RUN_MINUTES:
               cfg_in.run_minutes = pwdata[tpc_pkg::MINUTES_WIDTH-1:0];
            tpc_pkg::CSR_CONFIRM_COUNT:
               cfg_in.confirm_count = pwdata[tpc_pkg::CONFIRM_WIDTH-1:0];
            tpc_pkg::CSR_STOP_DELAY:
               cfg_in.stop_delay = pwdata[tpc_pkg::DELAY_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.network_id    <= tpc_pkg::NETWORK_ID_RESET;
         cfg_ff.run_minutes   <= tpc_pkg::RUN_MINUTES_RESET;
         cfg_ff.confirm_count <= tpc_pkg::CONFIRM_COUNT_RESET;
         cfg_ff.stop_delay    <= tpc_pkg::STOP_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         tpc_pkg::CSR_NETWORK_ID:    prdata = 32'(cfg_ff.network_id);
         tpc_pkg::CSR_RUN_MINUTES:   prdata = 32'(cfg_ff.run_minutes);
         tpc_pkg::CSR_CONFIRM_COUNT: prdata = 32'(cfg_ff.confirm_count);
         tpc_pkg::CSR_STOP_DELAY:    prdata = 32'(cfg_ff.stop_delay);
         default:                    prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Tank pump controller testbench
// Sends level reports, button presses and ticks into the unit. It predicts
// each readout with its own model of the controller and compares every
// result transfer with that prediction, field by field. The run moves
// through several register settings and several patterns of idle and stall.
// ----------------------------------------------------------------------------
module tb;
   import tpc_pkg::*;

   localparam logic [1:0] ACTION_UNUSED = 2'd3;
   localparam int PHASE_COUNT     = 6;
   localparam int PHASE_ITEMS     = 320;
   localparam int PRESSURE_CYCLES = 60;
   localparam int DRAIN_CYCLES    = 8;

   typedef struct packed {
      logic                     pump_on;
      logic [1:0]               level_state;
      logic [1:0]               display_mode;
      logic [MINUTES_WIDTH-1:0] display_minutes;
   } readout_type;

   typedef struct packed {
      item_type    item;
      logic        typed;
      readout_type want;
   } drill_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_action = ACTION_REPORT;
   logic                      req_msg_complete = 1'b0;
   logic [NETWORK_WIDTH-1:0]  req_report_network = '0;
   logic [1:0]                req_status_code = STATUS_FULL;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b1;
   logic                      rsp_pump_on;
   logic [1:0]                rsp_level_state;
   logic [1:0]                rsp_display_mode;
   logic [MINUTES_WIDTH-1:0]  rsp_display_minutes;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   cfg_type     cfg;
   state_type   st;
   readout_type pending_readouts [$];
   int          sender_idle_pct = 16;
   int          receiver_idle_pct = 84;
   logic        hold_active = 1'b0;
   logic        pressure_start = 1'b0;
   int          mismatch_count = 0;

   tank_pump_controller_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_msg_complete    (req_msg_complete),
      .req_report_network  (req_report_network),
      .req_status_code     (req_status_code),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pump_on         (rsp_pump_on),
      .rsp_level_state     (rsp_level_state),
      .rsp_display_mode    (rsp_display_mode),
      .rsp_display_minutes (rsp_display_minutes),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always #6 clock = ~clock;

   function automatic logic [SECONDS_WIDTH-1:0] run_ticks();
      logic [MINUTES_WIDTH-1:0] m;
      m = cfg.run_minutes;
      if (m < RUN_MINUTES_LOW || m > RUN_MINUTES_HIGH) begin
         m = RUN_MINUTES_DEFAULT;
      end
      return SECONDS_WIDTH'(int'(m) * TICKS_PER_MINUTE);
   endfunction

   function automatic readout_type advance_controller(input item_type it);
      readout_type r;
      int          mins;
      case (it.action)
         ACTION_REPORT: begin
            if (it.msg_complete && it.report_network == cfg.network_id) begin
               if (it.status_code == STATUS_FULL) begin
                  st.shown_mode = DISP_FULL;
                  st.full_streak = st.full_streak + 1'b1;
                  if (st.full_streak >= cfg.confirm_count) begin
                     st.pump_running = 1'b0;
                     st.seconds_left = run_ticks();
                     st.full_streak = '0;
                     st.level_held = LEVEL_FULL;
                  end
               end else begin
                  st.full_streak = '0;
               end
               if (it.status_code == STATUS_EMPTY) begin
                  st.shown_mode = DISP_EMPTY;
                  st.empty_streak = st.empty_streak + 1'b1;
                  if (st.empty_streak >= cfg.confirm_count) begin
                     st.pump_running = 1'b1;
                     st.empty_streak = '0;
                     st.level_held = LEVEL_EMPTY;
                  end
               end else begin
                  st.empty_streak = '0;
               end
               if (it.status_code == STATUS_NORMAL) begin
                  st.normal_streak = st.normal_streak + 1'b1;
                  if (st.normal_streak >= cfg.confirm_count) begin
                     st.level_held = LEVEL_NORMAL;
                     st.normal_streak = '0;
                  end
               end else begin
                  st.normal_streak = '0;
               end
            end
         end
         ACTION_BUTTON: begin
            if (!st.pump_running) begin
               st.pump_running = 1'b1;
               st.seconds_left = run_ticks();
            end else begin
               st.pump_running = 1'b0;
            end
         end
         ACTION_TICK: begin
            if (st.pump_running) begin
               if (st.seconds_left != 0) begin
                  st.seconds_left = st.seconds_left - 1'b1;
               end
               mins = int'(st.seconds_left) / TICKS_PER_MINUTE + 1;
               if (mins > 255) begin
                  mins = 255;
               end
               st.shown_mode = DISP_NUMBER;
               st.shown_minutes = MINUTES_WIDTH'(mins);
               if (st.seconds_left == 0 || st.level_held == LEVEL_FULL) begin
                  st.stop_streak = st.stop_streak + 1'b1;
                  if (st.stop_streak >= cfg.stop_delay) begin
                     st.pump_running = 1'b0;
                     st.seconds_left = run_ticks();
                     st.stop_streak = '0;
                     st.shown_mode = DISP_BLANK;
                  end
               end else begin
                  st.stop_streak = '0;
               end
            end
         end
         default: ;
      endcase
      r.pump_on = st.pump_running;
      r.level_state = st.level_held;
      r.display_mode = st.shown_mode;
      r.display_minutes = (st.shown_mode == DISP_NUMBER) ? st.shown_minutes : '0;
      return r;
   endfunction

   function automatic drill_row_type drill_row(
      input logic [1:0] action, input logic complete, input logic [NETWORK_WIDTH-1:0] net,
      input logic [1:0] status, input logic typed, input logic pump, input logic [1:0] level,
      input logic [1:0] mode, input logic [MINUTES_WIDTH-1:0] mins
   );
      drill_row_type r;
      r.item = '{action, complete, net, status};
      r.typed = typed;
      r.want = '{pump, level, mode, mins};
      return r;
   endfunction

   function automatic item_type random_item();
      item_type it;
      it.action = 2'($urandom_range(3));
      it.msg_complete = 1'($urandom_range(1));
      it.report_network = NETWORK_WIDTH'($urandom_range(16383));
      it.status_code = 2'($urandom_range(3));
      return it;
   endfunction

   task automatic push_item(input item_type it, input logic typed, input readout_type want);
      readout_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= it.action;
      req_msg_complete <= it.msg_complete;
      req_report_network <= it.report_network;
      req_status_code <= it.status_code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = advance_controller(it);
      pending_readouts.push_back(typed ? want : predicted);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_readouts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [CSR_DATA_WIDTH-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_WIDTH'({index, 2'b00});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_NETWORK_ID:    cfg.network_id = value[NETWORK_WIDTH-1:0];
         CSR_RUN_MINUTES:   cfg.run_minutes = value[MINUTES_WIDTH-1:0];
         CSR_CONFIRM_COUNT: cfg.confirm_count = value[CONFIRM_WIDTH-1:0];
         CSR_STOP_DELAY:    cfg.stop_delay = value[DELAY_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input cfg_type c);
      write_reg(CSR_NETWORK_ID, CSR_DATA_WIDTH'(c.network_id));
      write_reg(CSR_RUN_MINUTES, CSR_DATA_WIDTH'(c.run_minutes));
      write_reg(CSR_CONFIRM_COUNT, CSR_DATA_WIDTH'(c.confirm_count));
      write_reg(CSR_STOP_DELAY, CSR_DATA_WIDTH'(c.stop_delay));
   endtask

   // Most traffic is runs of ticks and runs of matching reports with one status,
   // so that streaks complete and the timer can run out.
   task automatic run_phase();
      int         sent;
      int         pick;
      int         n;
      logic [1:0] code;
      item_type   it;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            n = ($urandom_range(3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 20);
            repeat (n) begin
               it = random_item();
               it.action = ACTION_TICK;
               push_item(it, 1'b0, '0);
               sent++;
            end
         end else if (pick < 75) begin
            code = 2'($urandom_range(3));
            n = $urandom_range(1, 8);
            repeat (n) begin
               it = random_item();
               it.action = ACTION_REPORT;
               it.status_code = code;
               if ($urandom_range(9) != 0) begin
                  it.msg_complete = 1'b1;
                  it.report_network = cfg.network_id;
               end
               push_item(it, 1'b0, '0);
               sent++;
            end
         end else if (pick < 85) begin
            it = random_item();
            it.action = ACTION_BUTTON;
            push_item(it, 1'b0, '0);
            sent++;
         end else begin
            push_item(random_item(), 1'b0, '0);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin : result_side
      readout_type got;
      readout_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_pump_on, rsp_level_state, rsp_display_mode, rsp_display_minutes};
         if (pending_readouts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected transfer at %0t: pump %0d level %0d mode %0d minutes %0d",
                        $time, got.pump_on, got.level_state, got.display_mode,
                        got.display_minutes);
            end
         end else begin
            want = pending_readouts.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch at %0t: expected pump %0d level %0d mode %0d minutes %0d",
                           $time, want.pump_on, want.level_state, want.display_mode,
                           want.display_minutes);
                  $display("                 got pump %0d level %0d mode %0d minutes %0d",
                           got.pump_on, got.level_state, got.display_mode,
                           got.display_minutes);
               end
            end
         end
      end
      rsp_stall <= hold_active | ($urandom_range(99) < receiver_idle_pct);
   end

   initial begin
      wait (pressure_start);
      @(posedge clock);
      hold_active <= 1'b1;
      repeat (PRESSURE_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      drill_row_type drills [$];
      cfg_type       phase_cfg [PHASE_COUNT];
      cfg = '{NETWORK_ID_RESET, RUN_MINUTES_RESET, CONFIRM_COUNT_RESET, STOP_DELAY_RESET};
      st = STATE_RESET;

      // Rows marked 1 carry the readout that follows from the reset settings.
      drills.push_back(drill_row(ACTION_UNUSED, 1'b1, 14'd2012, STATUS_FULL,
                                 1'b1, 1'b0, LEVEL_NORMAL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_TICK, 1'b1, 14'd2012, STATUS_FULL,
                                 1'b1, 1'b0, LEVEL_NORMAL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_REPORT, 1'b0, 14'd2012, STATUS_FULL,
                                 1'b1, 1'b0, LEVEL_NORMAL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_REPORT, 1'b1, 14'd9999, STATUS_FULL,
                                 1'b1, 1'b0, LEVEL_NORMAL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_REPORT, 1'b1, 14'd16383, STATUS_EMPTY,
                                 1'b1, 1'b0, LEVEL_NORMAL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_REPORT, 1'b1, 14'd0, STATUS_NORMAL,
                                 1'b1, 1'b0, LEVEL_NORMAL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_BUTTON, 1'b0, 14'd0, STATUS_FULL,
                                 1'b1, 1'b1, LEVEL_NORMAL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_TICK, 1'b1, 14'd16383, STATUS_OTHER,
                                 1'b1, 1'b1, LEVEL_NORMAL, DISP_NUMBER, 8'd30));
      drills.push_back(drill_row(ACTION_REPORT, 1'b1, 14'd2012, STATUS_FULL,
                                 1'b1, 1'b1, LEVEL_NORMAL, DISP_FULL, 8'd0));
      drills.push_back(drill_row(ACTION_REPORT, 1'b1, 14'd2012, STATUS_FULL,
                                 1'b1, 1'b1, LEVEL_NORMAL, DISP_FULL, 8'd0));
      drills.push_back(drill_row(ACTION_REPORT, 1'b1, 14'd2012, STATUS_FULL,
                                 1'b1, 1'b0, LEVEL_FULL, DISP_FULL, 8'd0));
      drills.push_back(drill_row(ACTION_REPORT, 1'b1, 14'd2012, STATUS_EMPTY,
                                 1'b1, 1'b0, LEVEL_FULL, DISP_EMPTY, 8'd0));
      drills.push_back(drill_row(ACTION_REPORT, 1'b1, 14'd2012, STATUS_OTHER,
                                 1'b0, 1'b0, LEVEL_FULL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_REPORT, 1'b1, 14'd2012, STATUS_EMPTY,
                                 1'b0, 1'b0, LEVEL_FULL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_REPORT, 1'b1, 14'd2012, STATUS_EMPTY,
                                 1'b0, 1'b0, LEVEL_FULL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_REPORT, 1'b1, 14'd2012, STATUS_EMPTY,
                                 1'b0, 1'b0, LEVEL_FULL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_TICK, 1'b0, 14'd0, STATUS_FULL,
                                 1'b0, 1'b0, LEVEL_FULL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_REPORT, 1'b1, 14'd2012, STATUS_NORMAL,
                                 1'b0, 1'b0, LEVEL_FULL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_REPORT, 1'b1, 14'd2012, STATUS_NORMAL,
                                 1'b0, 1'b0, LEVEL_FULL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_REPORT, 1'b1, 14'd2012, STATUS_NORMAL,
                                 1'b0, 1'b0, LEVEL_FULL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_BUTTON, 1'b1, 14'd16383, STATUS_OTHER,
                                 1'b0, 1'b0, LEVEL_FULL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_BUTTON, 1'b0, 14'd9999, STATUS_NORMAL,
                                 1'b0, 1'b0, LEVEL_FULL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_REPORT, 1'b0, 14'd16383, STATUS_OTHER,
                                 1'b0, 1'b0, LEVEL_FULL, DISP_BLANK, 8'd0));
      drills.push_back(drill_row(ACTION_UNUSED, 1'b1, 14'd16383, STATUS_OTHER,
                                 1'b0, 1'b0, LEVEL_FULL, DISP_BLANK, 8'd0));

      phase_cfg[0] = '{14'd0, 8'd1, 3'd0, 4'd0};
      phase_cfg[1] = '{14'd9999, 8'd0, 3'd7, 4'd15};
      phase_cfg[2] = '{14'd16383, 8'd255, 3'd1, 4'd1};
      phase_cfg[3] = '{14'($urandom_range(9999)), 8'd180, 3'd2, 4'd3};
      phase_cfg[4] = '{14'd2012, 8'd2, 3'd3, 4'd5};
      phase_cfg[5] = '{14'($urandom_range(9999)), 8'd1, 3'd4, 4'd8};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (drills[i]) begin
         push_item(drills[i].item, drills[i].typed, drills[i].want);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         if (p == 2) begin
            sender_idle_pct = 84;
            receiver_idle_pct = 16;
         end else if (p == 4) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         apply_settings(phase_cfg[p]);
         if (p == 4) begin
            pressure_start = 1'b1;
         end
         run_phase();
      end
      settle();

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
